@@ hdl/bfpm_pkg.sv @@
// shared types, widths and constants of the battery fault persistence monitor
package bfpm_pkg;

   // field widths
   localparam int MvWidth    = 16;
   localparam int TempWidth  = 12;
   localparam int StampWidth = 32;
   localparam int NumChan    = 6;
   localparam int CsrIdxW    = 3;
   localparam int CsrDataW   = 16;

   // packed beat widths, padded to whole bytes
   localparam int ReqFieldBits = 2 * MvWidth + TempWidth + StampWidth + 1;
   localparam int ReqDataW     = ((ReqFieldBits + 7) / 8) * 8;
   localparam int RspFieldBits = 2 * NumChan;
   localparam int RspDataW     = ((RspFieldBits + 7) / 8) * 8;

   typedef logic [MvWidth-1:0]           mv_type;
   typedef logic signed [TempWidth-1:0]  temp_type;
   typedef logic [StampWidth-1:0]        stamp_type;
   typedef logic [NumChan-1:0]           chan_mask_type;

   // channel bit positions
   localparam int ChOvWarn  = 0;
   localparam int ChOvFault = 1;
   localparam int ChUvWarn  = 2;
   localparam int ChUvFault = 3;
   localparam int ChOtWarn  = 4;
   localparam int ChOtFault = 5;

   // latched fault channels, cleared by the manual clear
   localparam chan_mask_type FaultMask = chan_mask_type'(6'b10_1010);

   // persistence times in ms
   localparam stamp_type HoldShortMs = stamp_type'(3000);
   localparam stamp_type HoldLongMs  = stamp_type'(4000);
   localparam stamp_type HoldMs [NumChan] = '{
      HoldShortMs, HoldLongMs, HoldLongMs, HoldShortMs, HoldShortMs, HoldLongMs
   };

   // fixed ot warn release level, 55.0 C
   localparam temp_type OtWarnClearDc = temp_type'(550);

   // register reset values
   localparam mv_type   OvWarnSetRst   = mv_type'(4250);
   localparam mv_type   OvWarnClearRst = mv_type'(4230);
   localparam mv_type   OvFaultRst     = mv_type'(4350);
   localparam mv_type   UvWarnSetRst   = mv_type'(2800);
   localparam mv_type   UvWarnClearRst = mv_type'(2900);
   localparam mv_type   UvFaultRst     = mv_type'(1700);
   localparam temp_type OtWarnSetRst   = temp_type'(580);
   localparam temp_type OtFaultRst     = temp_type'(650);

   // register indexes
   typedef enum logic [CsrIdxW-1:0] {
      REG_OV_WARN_SET   = 3'd0,
      REG_OV_WARN_CLEAR = 3'd1,
      REG_OV_FAULT      = 3'd2,
      REG_UV_WARN_SET   = 3'd3,
      REG_UV_WARN_CLEAR = 3'd4,
      REG_UV_FAULT      = 3'd5,
      REG_OT_WARN_SET   = 3'd6,
      REG_OT_FAULT      = 3'd7
   } csr_idx_type;

endpackage

@@ hdl/battery_fault_persistence_monitor.sv @@
// battery fault persistence monitor: six debounced threshold channels per tick
// path: accepted req beat -> input register -> result register -> rsp beat
// one beat per cycle unless rsp stalls; the six channels compare and subtract in parallel
// the armed flags feed back within the single evaluation cycle, so ticks chain back to back
// reset: synchronous, clears armed flags and valid flags, loads default thresholds
// start stamps have no reset and are read only while their channel is armed
module battery_fault_persistence_monitor (
   input  logic                           clock,
   input  logic                           reset,
   // max_cell_mv[15:0], min_cell_mv[31:16], max_temp_dc[43:32],
   // now_ms[75:44], clear_latched[76], zero fill above
   input  logic [bfpm_pkg::ReqDataW-1:0]  req_tdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // reported_mask[5:0], armed_mask[11:6], zero fill above
   output logic [bfpm_pkg::RspDataW-1:0]  rsp_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic                           csr_we,
   input  bfpm_pkg::csr_idx_type          csr_index,
   input  logic [bfpm_pkg::CsrDataW-1:0]  csr_wdata
);
   import bfpm_pkg::*;

   // threshold registers
   mv_type   ov_warn_set_ff, ov_warn_clear_ff, ov_fault_ff;
   mv_type   uv_warn_set_ff, uv_warn_clear_ff, uv_fault_ff;
   temp_type ot_warn_set_ff, ot_fault_ff;

   // input register
   logic      in_vld_ff;
   mv_type    max_cell_ff, min_cell_ff;
   temp_type  max_temp_ff;
   stamp_type now_ff;
   logic      clear_ff;

   // channel state
   chan_mask_type armed_ff, armed_in;
   stamp_type     stamp_ff [NumChan];

   // result register
   logic          rsp_vld_ff;
   chan_mask_type rep_ff, rep_in, armed_out_ff;

   logic          advance;
   chan_mask_type cond, release_c, armed_pre, arm_now;
   stamp_type     elapsed [NumChan];

   // handshake: the eval stage moves when the result slot is free or being taken
   assign advance    = in_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(RspDataW - RspFieldBits){1'b0}}, armed_out_ff, rep_ff};

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_warn_set_ff   <= OvWarnSetRst;
         ov_warn_clear_ff <= OvWarnClearRst;
         ov_fault_ff      <= OvFaultRst;
         uv_warn_set_ff   <= UvWarnSetRst;
         uv_warn_clear_ff <= UvWarnClearRst;
         uv_fault_ff      <= UvFaultRst;
         ot_warn_set_ff   <= OtWarnSetRst;
         ot_fault_ff      <= OtFaultRst;
      end else if (csr_we) begin
         case (csr_index)
            REG_OV_WARN_SET:   ov_warn_set_ff   <= csr_wdata;
            REG_OV_WARN_CLEAR: ov_warn_clear_ff <= csr_wdata;
            REG_OV_FAULT:      ov_fault_ff      <= csr_wdata;
            REG_UV_WARN_SET:   uv_warn_set_ff   <= csr_wdata;
            REG_UV_WARN_CLEAR: uv_warn_clear_ff <= csr_wdata;
            REG_UV_FAULT:      uv_fault_ff      <= csr_wdata;
            REG_OT_WARN_SET:   ot_warn_set_ff   <= temp_type'(csr_wdata[TempWidth-1:0]);
            REG_OT_FAULT:      ot_fault_ff      <= temp_type'(csr_wdata[TempWidth-1:0]);
            default: ;
         endcase
      end
   end

   // input register control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         max_cell_ff <= req_tdata[MvWidth-1:0];
         min_cell_ff <= req_tdata[2*MvWidth-1:MvWidth];
         max_temp_ff <= temp_type'(req_tdata[2*MvWidth+TempWidth-1:2*MvWidth]);
         now_ff      <= req_tdata[2*MvWidth+TempWidth+StampWidth-1:2*MvWidth+TempWidth];
         clear_ff    <= req_tdata[ReqFieldBits-1];
      end
   end

   // channel conditions and warning releases
   always_comb begin
      cond[ChOvWarn]       = max_cell_ff >= ov_warn_set_ff;
      cond[ChOvFault]      = max_cell_ff >= ov_fault_ff;
      cond[ChUvWarn]       = min_cell_ff <= uv_warn_set_ff;
      cond[ChUvFault]      = min_cell_ff <= uv_fault_ff;
      cond[ChOtWarn]       = max_temp_ff >= ot_warn_set_ff;
      cond[ChOtFault]      = max_temp_ff >= ot_fault_ff;
      release_c            = '0;
      release_c[ChOvWarn]  = max_cell_ff < ov_warn_clear_ff;
      release_c[ChUvWarn]  = min_cell_ff >= uv_warn_clear_ff;
      release_c[ChOtWarn]  = max_temp_ff < OtWarnClearDc;
   end

   // per channel arm, report and disarm; manual clear applies first
   always_comb begin
      armed_pre = clear_ff ? (armed_ff & ~FaultMask) : armed_ff;
      armed_in  = armed_pre;
      arm_now   = '0;
      rep_in    = '0;
      for (int i = 0; i < NumChan; i++) begin
         elapsed[i] = now_ff - stamp_ff[i];
         if (cond[i]) begin
            if (!armed_pre[i]) begin
               armed_in[i] = 1'b1;
               arm_now[i]  = 1'b1;
            end else begin
               rep_in[i] = elapsed[i] >= HoldMs[i];
            end
         end else if (release_c[i]) begin
            armed_in[i] = 1'b0;
         end
      end
   end

   // armed flags and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff   <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (advance) begin
            armed_ff <= armed_in;
         end
         if (advance) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // start stamps and result payload
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < NumChan; i++) begin
            if (arm_now[i]) begin
               stamp_ff[i] <= now_ff;
            end
         end
         rep_ff       <= rep_in;
         armed_out_ff <= armed_in;
      end
   end

endmodule

@@ tb/sv/tb_battery_fault_persistence_monitor.sv @@
// self-checking testbench for the battery fault persistence monitor
module tb_battery_fault_persistence_monitor;
   import bfpm_pkg::*;

   // one evaluation tick as sent on the req channel
   typedef struct {
      mv_type    max_mv;
      mv_type    min_mv;
      temp_type  temp;
      stamp_type now;
      logic      clr;
   } tick_item_type;

   // predicted result of one tick
   typedef struct {
      chan_mask_type reported;
      chan_mask_type armed;
   } mask_pair_type;

   localparam int QuietLimit = 2000;
   localparam chan_mask_type LatchedChans = 6'b10_1010;
   localparam chan_mask_type LongHoldChans = 6'b10_0110;
   localparam stamp_type ShortHold = 32'd3000;
   localparam stamp_type LongHold = 32'd4000;
   localparam temp_type OtReleaseDc = 12'sd550;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [RspDataW-1:0] rsp_tdata;
   logic rsp_tvalid;
   logic rsp_tready = 1'b1;
   logic csr_we = 1'b0;
   csr_idx_type csr_index = REG_OV_WARN_SET;
   logic [CsrDataW-1:0] csr_wdata = '0;

   // predictor copy of thresholds and channel state
   mv_type cfg_ov_set = 16'd4250;
   mv_type cfg_ov_clear = 16'd4230;
   mv_type cfg_ov_fault = 16'd4350;
   mv_type cfg_uv_set = 16'd2800;
   mv_type cfg_uv_clear = 16'd2900;
   mv_type cfg_uv_fault = 16'd1700;
   temp_type cfg_ot_warn = 12'sd580;
   temp_type cfg_ot_fault = 12'sd650;
   chan_mask_type armed_now = '0;
   stamp_type arm_stamp [NumChan];

   tick_item_type pending_ticks [$];
   mask_pair_type expected_masks [$];
   tick_item_type on_bus;
   tick_item_type next_tick;
   mask_pair_type due_tick;
   mask_pair_type due_beat;
   stamp_type cur_ms = 32'd10000;

   int burst_left = 0;
   int gap_left = 0;
   int stall_left = 0;
   int quiet_cycles = 0;
   bit send_idle = 1'b1;
   bit recv_stall = 1'b1;
   int ticks_sent = 0;
   int beats_checked = 0;
   int error_count = 0;
   chan_mask_type reports_seen = '0;
   chan_mask_type armed_seen = '0;

   battery_fault_persistence_monitor uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // advance the channel state by one tick, return report and armed masks
   function automatic mask_pair_type predict_tick(tick_item_type t);
      chan_mask_type hit;
      chan_mask_type drop;
      chan_mask_type rep;
      stamp_type hold;
      stamp_type elapsed;
      mask_pair_type res;
      rep = '0;
      drop = '0;
      if (t.clr) begin
         armed_now = armed_now & ~LatchedChans;
      end
      hit[ChOvWarn] = t.max_mv >= cfg_ov_set;
      drop[ChOvWarn] = t.max_mv < cfg_ov_clear;
      hit[ChOvFault] = t.max_mv >= cfg_ov_fault;
      hit[ChUvWarn] = t.min_mv <= cfg_uv_set;
      drop[ChUvWarn] = t.min_mv >= cfg_uv_clear;
      hit[ChUvFault] = t.min_mv <= cfg_uv_fault;
      hit[ChOtWarn] = t.temp >= cfg_ot_warn;
      drop[ChOtWarn] = t.temp < OtReleaseDc;
      hit[ChOtFault] = t.temp >= cfg_ot_fault;
      for (int ch = 0; ch < NumChan; ch++) begin
         hold = LongHoldChans[ch] ? LongHold : ShortHold;
         if (hit[ch]) begin
            if (!armed_now[ch]) begin
               // arming tick is never reported
               armed_now[ch] = 1'b1;
               arm_stamp[ch] = t.now;
            end else begin
               elapsed = t.now - arm_stamp[ch];
               rep[ch] = elapsed >= hold;
            end
         end else if (drop[ch]) begin
            armed_now[ch] = 1'b0;
         end
      end
      res.reported = rep;
      res.armed = armed_now;
      return res;
   endfunction

   function automatic int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   function automatic int near(int thr, int lo, int hi);
      return clamp(thr + int'($urandom_range(0, 80)) - 40, lo, hi);
   endfunction

   task automatic add_tick(mv_type mx, mv_type mn, temp_type tp, stamp_type nw, logic cl);
      tick_item_type t;
      t.max_mv = mx;
      t.min_mv = mn;
      t.temp = tp;
      t.now = nw;
      t.clr = cl;
      pending_ticks.push_back(t);
   endtask

   // segments of steady levels around the thresholds, time moving forward
   task automatic queue_random(int count);
      int seg_left;
      int vmax;
      int vmin;
      int temp;
      int r;
      seg_left = 0;
      vmax = 3700;
      vmin = 3600;
      temp = 250;
      for (int i = 0; i < count; i++) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(1, 12);
            r = $urandom_range(0, 9);
            vmax = (r < 2) ? int'($urandom_range(0, 65535)) :
                   (r < 4) ? near(cfg_ov_set, 0, 65535) :
                   (r == 4) ? near(cfg_ov_clear, 0, 65535) :
                   (r < 7) ? near(cfg_ov_fault, 0, 65535) :
                   int'($urandom_range(3000, 4100));
            r = $urandom_range(0, 9);
            vmin = (r < 2) ? int'($urandom_range(0, 65535)) :
                   (r < 4) ? near(cfg_uv_set, 0, 65535) :
                   (r == 4) ? near(cfg_uv_clear, 0, 65535) :
                   (r < 7) ? near(cfg_uv_fault, 0, 65535) :
                   int'($urandom_range(3000, 4100));
            r = $urandom_range(0, 9);
            temp = (r == 0) ? int'($urandom_range(0, 1900)) - 400 :
                   (r < 3) ? near(cfg_ot_warn, -400, 1500) :
                   (r == 3) ? near(OtReleaseDc, -400, 1500) :
                   (r < 6) ? near(cfg_ot_fault, -400, 1500) :
                   int'($urandom_range(0, 500));
         end
         seg_left--;
         // small jitter on each tick
         vmax = clamp(vmax + int'($urandom_range(0, 16)) - 8, 0, 65535);
         vmin = clamp(vmin + int'($urandom_range(0, 16)) - 8, 0, 65535);
         temp = clamp(temp + int'($urandom_range(0, 8)) - 4, -400, 1500);
         // mostly steady time steps, multiples of 250 ms land on the hold limits
         r = $urandom_range(0, 79);
         if (r == 0) begin
            cur_ms = $urandom;
         end else if (r < 40) begin
            cur_ms = cur_ms + 250 * $urandom_range(0, 4);
         end else begin
            cur_ms = cur_ms + $urandom_range(0, 900);
         end
         add_tick(16'(vmax), 16'(vmin), 12'(temp), cur_ms, $urandom_range(0, 19) == 0);
      end
   endtask

   // hold off until all queued ticks are sent and every result has come back
   task automatic wait_drained();
      while (pending_ticks.size() != 0 || req_tvalid || expected_masks.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic set_reg(csr_idx_type idx, logic [CsrDataW-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_OV_WARN_SET: cfg_ov_set = val;
         REG_OV_WARN_CLEAR: cfg_ov_clear = val;
         REG_OV_FAULT: cfg_ov_fault = val;
         REG_UV_WARN_SET: cfg_uv_set = val;
         REG_UV_WARN_CLEAR: cfg_uv_clear = val;
         REG_UV_FAULT: cfg_uv_fault = val;
         REG_OT_WARN_SET: cfg_ot_warn = temp_type'(val[TempWidth-1:0]);
         REG_OT_FAULT: cfg_ot_fault = temp_type'(val[TempWidth-1:0]);
         default: ;
      endcase
   endtask

   // write all eight thresholds, temperature words get random upper bits
   task automatic load_thresholds(int ovs, int ovc, int ovf, int uvs, int uvc, int uvf,
                                  int otw, int otf);
      set_reg(REG_OV_WARN_SET, 16'(ovs));
      set_reg(REG_OV_WARN_CLEAR, 16'(ovc));
      set_reg(REG_OV_FAULT, 16'(ovf));
      set_reg(REG_UV_WARN_SET, 16'(uvs));
      set_reg(REG_UV_WARN_CLEAR, 16'(uvc));
      set_reg(REG_UV_FAULT, 16'(uvf));
      set_reg(REG_OT_WARN_SET, {4'($urandom_range(0, 15)), 12'(otw)});
      set_reg(REG_OT_FAULT, {4'($urandom_range(0, 15)), 12'(otf)});
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // req driver: bursts of beats with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            due_tick = predict_tick(on_bus);
            expected_masks.push_back(due_tick);
            ticks_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
               next_tick = pending_ticks.pop_front();
               on_bus <= next_tick;
               req_tdata <= {3'b000, next_tick.clr, next_tick.now, next_tick.temp,
                             next_tick.min_mv, next_tick.max_mv};
               req_tvalid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 16);
                  gap_left <= send_idle ? $urandom_range(0, 6) : 0;
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // rsp ready: alternating ready and stall runs while recv_stall is set, else always ready
   always @(posedge clock) begin
      if (!recv_stall) begin
         rsp_tready <= 1'b1;
      end else if (stall_left == 0) begin
         rsp_tready <= ~rsp_tready;
         stall_left <= rsp_tready ? $urandom_range(0, 4) : $urandom_range(0, 7);
      end else begin
         stall_left <= stall_left - 1;
      end
   end

   // rsp monitor: compare each beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_masks.size() == 0) begin
            $error("rsp beat with no tick outstanding: %h", rsp_tdata);
            error_count++;
         end else begin
            due_beat = expected_masks.pop_front();
            beats_checked++;
            reports_seen = reports_seen | rsp_tdata[5:0];
            armed_seen = armed_seen | rsp_tdata[11:6];
            if (rsp_tdata[5:0] !== due_beat.reported) begin
               $error("reported_mask: expected %b, got %b", due_beat.reported, rsp_tdata[5:0]);
               error_count++;
            end
            if (rsp_tdata[11:6] !== due_beat.armed) begin
               $error("armed_mask: expected %b, got %b", due_beat.armed, rsp_tdata[11:6]);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int base;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed ticks on reset thresholds
      add_tick(16'd3700, 16'd3600, 12'sd250, 32'd1000, 1'b0);
      // every channel arms on field extremes, then short and long holds expire
      add_tick(16'd65535, 16'd0, 12'sd1500, 32'd2000, 1'b0);
      add_tick(16'd65535, 16'd0, 12'sd1500, 32'd4999, 1'b0);
      add_tick(16'd65535, 16'd0, 12'sd1500, 32'd5000, 1'b0);
      add_tick(16'd65535, 16'd0, 12'sd1500, 32'd6000, 1'b0);
      // warnings between set and clear levels keep their stamps
      add_tick(16'd4240, 16'd2850, 12'sd560, 32'd6100, 1'b0);
      add_tick(16'd4260, 16'd2750, 12'sd590, 32'd6200, 1'b0);
      // warnings release, faults stay latched without condition
      add_tick(16'd4229, 16'd2900, 12'sd549, 32'd6300, 1'b0);
      // clear with condition re-arms, clear without condition drops
      add_tick(16'd4400, 16'd3000, 12'sd700, 32'd6400, 1'b1);
      add_tick(16'd3700, 16'd3600, 12'sd250, 32'd6500, 1'b1);
      // timestamp wrap
      add_tick(16'd4300, 16'd3600, -12'sd400, 32'hFFFF_F000, 1'b0);
      add_tick(16'd4300, 16'd3600, -12'sd400, 32'h0000_0400, 1'b0);
      add_tick(16'd0, 16'd65535, 12'sd0, 32'hFFFF_FFFF, 1'b0);
      // exact threshold values
      add_tick(16'd3700, 16'd1700, 12'sd650, 32'h0000_0000, 1'b0);
      add_tick(16'd3700, 16'd1701, 12'sd649, 32'd3000, 1'b0);
      add_tick(16'd4250, 16'd2800, 12'sd580, 32'd4000, 1'b0);

      for (int phase = 0; phase < 6; phase++) begin
         send_idle = (phase % 3) != 1;
         recv_stall = (phase % 3) != 2;
         case (phase)
            1, 5: begin
               base = $urandom_range(4100, 4300);
               load_thresholds(base, base - int'($urandom_range(0, 60)),
                               base + int'($urandom_range(0, 150)),
                               2700 + int'($urandom_range(0, 300)),
                               3000 + int'($urandom_range(0, 150)),
                               1200 + int'($urandom_range(0, 800)),
                               450 + int'($urandom_range(0, 250)),
                               600 + int'($urandom_range(0, 200)));
            end
            2: load_thresholds(0, 0, 0, 0, 0, 0, -400, -400);
            3: load_thresholds(65535, 65535, 65535, 65535, 65535, 65535, 1500, 1500);
            4: load_thresholds(4100, 4300, 4000, 2900, 2700, 3200, 500, 400);
            default: ;
         endcase
         if (phase == 5) begin
            cur_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
         end
         // mid-phase pause lets every result drain before sending more
         queue_random(100);
         wait_drained();
         queue_random(100);
         wait_drained();
      end

      repeat (8) @(posedge clock);
      $display("%0d ticks sent over six threshold settings, %0d result beats checked",
               ticks_sent, beats_checked);
      $display("channels seen reporting %b, channels seen armed %b", reports_seen, armed_seen);
      if (error_count == 0 && expected_masks.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
